// File: design/ring_load_balancer_top_assert.svh
// assertion macros shared by the ring load balancer checkers
`ifndef RING_LOAD_BALANCER_TOP_ASSERT_SVH
`define RING_LOAD_BALANCER_TOP_ASSERT_SVH

// condition holds in the same cycle as the antecedent
`define RLB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the antecedent
`define RLB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rlb_pkg.sv
// shared types and constants of the ring load balancer
`timescale 1ns / 1ps
`default_nettype none

package rlb_pkg;

    // field widths
    localparam int LOAD_W     = 32;
    localparam int IDX_W      = 6;
    localparam int COUNT_W    = 7;
    localparam int ALPHA_W    = 16;
    localparam int PROD_W     = LOAD_W + ALPHA_W;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int SDATA_W    = 8;
    localparam int MDATA_W    = 2 * LOAD_W;
    localparam int MUSER_W    = 2;

    // register reset values
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd2;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd1399;

    // largest load, loads saturate here
    localparam logic [LOAD_W-1:0] LOAD_MAX = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_BIN_COUNT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ALPHA     = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INC,
        S_SCAN,
        S_MUL,
        S_CMP,
        S_NBR_L,
        S_NBR_R,
        S_MERGE,
        S_COPY,
        S_RDX,
        S_GETX,
        S_SPLIT_LO,
        S_SPLIT_HI,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// File: design/rlb_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module rlb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: design/ring_load_balancer_top.sv
// ring load balancer: bin loads on a ring, merge of the lightest bin and split of the hot bin
//
// Each transfer on the slave stream names a bin whose load grows by one. The loads sit in one
// memory with a single read and a single write port, and a small sequencer walks it: it bumps
// the bin, scans for the first least-loaded bin, tests the bin against alpha_q8 times that
// minimum with one 16x32 multiplier, and on a rebalance merges the lightest bin into
// its lighter ring neighbour, closes the gap and opens a slot to split the hot bin in two.
// A final scan gives the minimum and maximum load. On a bad index no bin is bumped and only the
// final scan runs. An item is taken only in the idle state, so the next transfer waits until
// the sequencer is through with the current one; its walk is set by the memory's one read per
// cycle, and a result still waiting in the output register holds the sequencer in its done
// state. After reset a clearing pass over all MAX_BINS bins zeroes the memory and no item is
// taken meanwhile; configuration writes are taken any time.
// The result sits in an output register, so the next item is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

module ring_load_balancer_top #(
    parameter int MAX_BINS = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [rlb_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [rlb_pkg::CFG_DATA_W-1:0] i_cfg_wr_data,
    // input stream
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [rlb_pkg::SDATA_W-1:0]    i_s_tdata,   // bin_index[5:0], zero pad
    // result stream
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic      [rlb_pkg::MDATA_W-1:0]    o_m_tdata,   // max_load[31:0], min_load[63:32]
    output logic      [rlb_pkg::MUSER_W-1:0]    o_m_tuser    // rebalanced[0], index_error[1]
);

    import rlb_pkg::*;

    localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CW = $clog2(MAX_BINS + 1);

    // control registers
    t_state             r_state, n_state;
    logic [CW-1:0]      r_k, n_k;
    logic [CW-1:0]      r_n, n_n;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [AW-1:0]      r_src, n_src;
    logic               r_up, n_up;
    logic               r_rd_vld, n_rd_vld;
    logic               r_final, n_final;
    logic               r_err, n_err;
    logic               r_reb, n_reb;
    logic               r_out_vld, n_out_vld;
    logic [COUNT_W-1:0] r_bin_count;
    logic [ALPHA_W-1:0] r_alpha;

    // payload registers
    logic [AW-1:0]      r_rd_idx, n_rd_idx;
    logic [AW-1:0]      r_u, n_u;
    logic [AW-1:0]      r_v, n_v;
    logic [LOAD_W-1:0]  r_min, n_min;
    logic [LOAD_W-1:0]  r_max, n_max;
    logic [LOAD_W-1:0]  r_lu, n_lu;
    logic [LOAD_W-1:0]  r_ll, n_ll;
    logic [LOAD_W-1:0]  r_x, n_x;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [MDATA_W-1:0] r_out_data, n_out_data;
    logic [MUSER_W-1:0] r_out_user, n_out_user;

    // memory port
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [LOAD_W-1:0]  ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [LOAD_W-1:0]  ram_rdata;

    // helpers
    logic [CW-1:0]      n_used;
    logic [IDX_W-1:0]   u_in;
    logic [AW-1:0]      v_left;
    logic [AW-1:0]      v_right;
    logic [AW-1:0]      u_adj;
    logic [LOAD_W:0]    inc_sum;
    logic [LOAD_W-1:0]  z_load;
    logic [AW-1:0]      z_idx;
    logic [LOAD_W:0]    merge_sum;
    logic [LOAD_W:0]    ceil_sum;

    rlb_ram #(
        .WIDTH(LOAD_W),
        .DEPTH(MAX_BINS)
    ) u_loads (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // bins in use, capped at the memory depth
    assign n_used = (32'(r_bin_count) > 32'(MAX_BINS)) ? CW'(MAX_BINS) : CW'(r_bin_count);
    assign u_in   = i_s_tdata[IDX_W-1:0];

    // ring neighbours of the lightest bin and the hot bin index after removal
    assign v_left  = (r_v == '0) ? AW'(r_n - CW'(1)) : r_v - AW'(1);
    assign v_right = ((CW'(r_v) + CW'(1)) == r_n) ? '0 : r_v + AW'(1);
    assign u_adj   = (r_v < r_u) ? r_u - AW'(1) : r_u;

    // adders and the lighter-neighbour select; the bump and merge sums saturate where used
    assign inc_sum   = {1'b0, ram_rdata} + (LOAD_W+1)'(1);
    assign z_load    = (r_ll < ram_rdata) ? r_ll : ram_rdata;
    assign z_idx     = (r_ll < ram_rdata) ? v_left : v_right;
    assign merge_sum = {1'b0, z_load} + {1'b0, r_min};
    assign ceil_sum  = {1'b0, r_x} + (LOAD_W+1)'(1);

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    // sequencer next state and memory control
    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_n        = r_n;
        n_cnt      = r_cnt;
        n_src      = r_src;
        n_up       = r_up;
        n_rd_vld   = 1'b0;
        n_final    = r_final;
        n_err      = r_err;
        n_reb      = r_reb;
        n_rd_idx   = r_rd_idx;
        n_u        = r_u;
        n_v        = r_v;
        n_min      = r_min;
        n_max      = r_max;
        n_lu       = r_lu;
        n_ll       = r_ll;
        n_x        = r_x;
        n_prod     = r_prod;
        n_out_data = r_out_data;
        n_out_user = r_out_user;
        n_out_vld  = r_out_vld && !i_m_tready;
        ram_we     = 1'b0;
        ram_waddr  = r_u;
        ram_wdata  = '0;
        ram_raddr  = r_u;

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_k[AW-1:0];
                if (r_k == CW'(MAX_BINS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            S_IDLE: begin
                ram_raddr = AW'(u_in);
                if (i_s_tvalid) begin
                    n_n   = n_used;
                    n_u   = AW'(u_in);
                    n_reb = 1'b0;
                    n_err = (32'(u_in) >= 32'(n_used));
                    n_k   = '0;
                    n_min = '0;
                    n_max = '0;
                    if (32'(u_in) >= 32'(n_used)) begin
                        n_final = 1'b1;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_INC;
                    end
                end
            end
            S_INC: begin
                // bump the named bin
                ram_we    = 1'b1;
                ram_waddr = r_u;
                ram_wdata = inc_sum[LOAD_W] ? LOAD_MAX : inc_sum[LOAD_W-1:0];
                n_lu      = inc_sum[LOAD_W] ? LOAD_MAX : inc_sum[LOAD_W-1:0];
                n_final   = (r_n < CW'(2));
                n_state   = S_SCAN;
            end
            S_SCAN: begin
                // pipelined pass: issue one read, compare the previous one
                if (r_k != r_n) begin
                    ram_raddr = r_k[AW-1:0];
                    n_k       = r_k + CW'(1);
                    n_rd_vld  = 1'b1;
                    n_rd_idx  = r_k[AW-1:0];
                end
                if (r_rd_vld) begin
                    if (r_rd_idx == '0 || ram_rdata < r_min) begin
                        n_min = ram_rdata;
                        n_v   = r_rd_idx;
                    end
                    if (r_rd_idx == '0 || ram_rdata > r_max) begin
                        n_max = ram_rdata;
                    end
                end
                if (r_k == r_n && !r_rd_vld) begin
                    if (r_final) begin
                        n_state = S_DONE;
                    end else if (r_v == r_u) begin
                        n_k     = '0;
                        n_final = 1'b1;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_prod  = r_alpha * r_min;
                n_state = S_CMP;
            end
            S_CMP: begin
                if ({{ALPHA_W-8{1'b0}}, r_lu, 8'h00} > r_prod) begin
                    n_reb   = 1'b1;
                    n_state = S_NBR_L;
                end else begin
                    n_k     = '0;
                    n_final = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_NBR_L: begin
                ram_raddr = v_left;
                n_state   = S_NBR_R;
            end
            S_NBR_R: begin
                ram_raddr = v_right;
                n_ll      = ram_rdata;
                n_state   = S_MERGE;
            end
            S_MERGE: begin
                // lightest bin into its lighter neighbour, then close the gap
                ram_we    = 1'b1;
                ram_waddr = z_idx;
                ram_wdata = merge_sum[LOAD_W] ? LOAD_MAX : merge_sum[LOAD_W-1:0];
                n_src     = r_v + AW'(1);
                n_cnt     = r_n - CW'(1) - CW'(r_v);
                n_up      = 1'b0;
                n_state   = S_COPY;
            end
            S_COPY: begin
                // pipelined move by one slot, down or up
                if (r_cnt != '0) begin
                    ram_raddr = r_src;
                    n_src     = r_up ? r_src - AW'(1) : r_src + AW'(1);
                    n_cnt     = r_cnt - CW'(1);
                    n_rd_vld  = 1'b1;
                    n_rd_idx  = r_src;
                end
                if (r_rd_vld) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_up ? r_rd_idx + AW'(1) : r_rd_idx - AW'(1);
                    ram_wdata = ram_rdata;
                end
                if (r_cnt == '0 && !r_rd_vld) begin
                    n_state = r_up ? S_SPLIT_LO : S_RDX;
                end
            end
            S_RDX: begin
                n_u       = u_adj;
                ram_raddr = u_adj;
                n_state   = S_GETX;
            end
            S_GETX: begin
                // open a slot above the hot bin
                n_x     = ram_rdata;
                n_src   = AW'(r_n - CW'(2));
                n_cnt   = r_n - CW'(2) - CW'(r_u);
                n_up    = 1'b1;
                n_state = S_COPY;
            end
            S_SPLIT_LO: begin
                ram_we    = 1'b1;
                ram_waddr = r_u;
                ram_wdata = r_x >> 1;
                n_state   = S_SPLIT_HI;
            end
            S_SPLIT_HI: begin
                ram_we    = 1'b1;
                ram_waddr = r_u + AW'(1);
                ram_wdata = ceil_sum[LOAD_W:1];
                n_k       = '0;
                n_final   = 1'b1;
                n_state   = S_SCAN;
            end
            S_DONE: begin
                if (!r_out_vld || i_m_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {r_min, r_max};
                    n_out_user = {r_err, r_reb};
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_k         <= '0;
            r_n         <= '0;
            r_cnt       <= '0;
            r_src       <= '0;
            r_up        <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_final     <= 1'b0;
            r_err       <= 1'b0;
            r_reb       <= 1'b0;
            r_out_vld   <= 1'b0;
            r_bin_count <= COUNT_RESET;
            r_alpha     <= ALPHA_RESET;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_n       <= n_n;
            r_cnt     <= n_cnt;
            r_src     <= n_src;
            r_up      <= n_up;
            r_rd_vld  <= n_rd_vld;
            r_final   <= n_final;
            r_err     <= n_err;
            r_reb     <= n_reb;
            r_out_vld <= n_out_vld;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    CFG_BIN_COUNT: r_bin_count <= i_cfg_wr_data[COUNT_W-1:0];
                    CFG_ALPHA:     r_alpha     <= i_cfg_wr_data[ALPHA_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_u        <= n_u;
        r_v        <= n_v;
        r_min      <= n_min;
        r_max      <= n_max;
        r_lu       <= n_lu;
        r_ll       <= n_ll;
        r_x        <= n_x;
        r_prod     <= n_prod;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

endmodule

`default_nettype wire

// File: design/rlb_checker.sv
// port level checks of the ring load balancer and their bind
`timescale 1ns / 1ps
`default_nettype none

`include "ring_load_balancer_top_assert.svh"

module rlb_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_s_tvalid,
    input wire logic                        o_s_tready,
    input wire logic                        o_m_tvalid,
    input wire logic                        i_m_tready,
    input wire logic [rlb_pkg::MDATA_W-1:0] o_m_tdata,
    input wire logic [rlb_pkg::MUSER_W-1:0] o_m_tuser
);

    import rlb_pkg::*;

    // the block is not ready in the cycle after it takes an item
    `RLB_ASSERT_NEXT(a_busy_after_take, i_s_tvalid && o_s_tready, !o_s_tready, "ready after transfer")

    // the smallest load never exceeds the largest
    `RLB_ASSERT_SAME(a_min_le_max, o_m_tvalid, o_m_tdata[MDATA_W-1:LOAD_W] <= o_m_tdata[LOAD_W-1:0], "min above max")

    // a bad index never comes with a rebalance
    `RLB_ASSERT_SAME(a_err_no_reb, o_m_tvalid, !(o_m_tuser[0] && o_m_tuser[1]), "rebalance on bad index")

    // a waiting result holds
    `RLB_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result dropped")

endmodule

bind ring_load_balancer_top rlb_checker u_rlb_checker (.*);

`default_nettype wire

// File: test/tb_ring_load_balancer_top.sv
// self-checking testbench for the ring load balancer: directed and random bin traffic
`timescale 1ns / 1ps

module tb_ring_load_balancer_top;
    import rlb_pkg::*;

    localparam int MAX_BINS         = 64;
    localparam int RAND_PHASES      = 12;
    localparam int PHASE_ITEMS      = 105;
    localparam int SINK_HOLD_CYCLES = 3000;
    localparam int TAIL_CYCLES      = 4 * MAX_BINS + 40;
    localparam int STALL_LIMIT      = 20000;

    // expected fields of one result transfer
    typedef struct packed {
        logic [LOAD_W-1:0] max_load;
        logic [LOAD_W-1:0] min_load;
        logic              rebalanced;
        logic              index_error;
    } t_load_stats;

    // tracks the ring of bin loads and the results still owed by the block
    class ring_balance_tracker;
        logic [LOAD_W-1:0]  loads [MAX_BINS];
        logic [COUNT_W-1:0] count_reg;
        logic [ALPHA_W-1:0] alpha_reg;
        t_load_stats        due_stats [$];
        int unsigned        fails;
        int unsigned        checked;
        int unsigned        rebal_seen;
        int unsigned        err_seen;

        function new();
            foreach (loads[k]) loads[k] = '0;
            count_reg  = COUNT_RESET;
            alpha_reg  = ALPHA_RESET;
            fails      = 0;
            checked    = 0;
            rebal_seen = 0;
            err_seen   = 0;
        endfunction

        function void set_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_BIN_COUNT) count_reg = data[COUNT_W-1:0];
            else if (idx == CFG_ALPHA) alpha_reg = data[ALPHA_W-1:0];
        endfunction

        function int pending();
            return due_stats.size();
        endfunction

        function logic [LOAD_W-1:0] sat_sum(logic [LOAD_W-1:0] a, logic [LOAD_W-1:0] b);
            logic [LOAD_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[LOAD_W] ? LOAD_MAX : s[LOAD_W-1:0];
        endfunction

        // merge the lightest bin away and split bin u, returns 1 when it happened
        function bit merge_and_split(int u, int n);
            int              v, k, lft, rgt, z;
            logic [LOAD_W-1:0] x;
            logic [LOAD_W:0]   up;
            logic [63:0]       lhs, rhs;
            if (n < 2) return 0;
            v = 0;
            for (k = 1; k < n; k++)
                if (loads[k] < loads[v]) v = k;
            if (v == u) return 0;
            lhs = {24'd0, loads[u], 8'd0};
            rhs = {48'd0, alpha_reg} * {32'd0, loads[v]};
            if (lhs <= rhs) return 0;
            // lighter ring neighbour takes the load, right one on a tie
            lft = (v == 0) ? n - 1 : v - 1;
            rgt = (v + 1 == n) ? 0 : v + 1;
            z = (loads[lft] < loads[rgt]) ? lft : rgt;
            loads[z] = sat_sum(loads[z], loads[v]);
            // close the gap left by the removed bin
            for (k = v; k < n - 1; k++) loads[k] = loads[k + 1];
            if (v < u) u--;
            // open a slot after u and split it into floor and ceil halves
            x = loads[u];
            for (k = n - 1; k > u + 1; k--) loads[k] = loads[k - 1];
            up = {1'b0, x} + 1'b1;
            loads[u]     = x >> 1;
            loads[u + 1] = up[LOAD_W:1];
            return 1;
        endfunction

        // accepted input transfer: update the ring and queue its result
        function void add_unit(logic [IDX_W-1:0] idx);
            int          n, u, k;
            t_load_stats e;
            n = (count_reg > MAX_BINS) ? MAX_BINS : int'(count_reg);
            u = int'(idx);
            e = '0;
            if (u >= n) begin
                e.index_error = 1'b1;
            end else begin
                loads[u]     = sat_sum(loads[u], 1);
                e.rebalanced = merge_and_split(u, n);
            end
            if (n > 0) begin
                e.max_load = loads[0];
                e.min_load = loads[0];
                for (k = 1; k < n; k++) begin
                    if (loads[k] > e.max_load) e.max_load = loads[k];
                    if (loads[k] < e.min_load) e.min_load = loads[k];
                end
            end
            due_stats.insert(due_stats.size(), e);
        endfunction

        function void check_field(string what, logic [LOAD_W-1:0] want, logic [LOAD_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
                fails++;
            end
        endfunction

        // accepted result transfer: compare with the oldest expectation
        function void compare_result(logic [MDATA_W-1:0] tdata, logic [MUSER_W-1:0] tuser);
            t_load_stats e;
            if (due_stats.size() == 0) begin
                $display("%0t: unexpected result, expected none, got tdata %h tuser %b",
                         $time, tdata, tuser);
                fails++;
                return;
            end
            e = due_stats.pop_front();
            checked++;
            if (e.rebalanced) rebal_seen++;
            if (e.index_error) err_seen++;
            check_field("max_load", e.max_load, tdata[LOAD_W-1:0]);
            check_field("min_load", e.min_load, tdata[2*LOAD_W-1:LOAD_W]);
            check_field("rebalanced", 32'(e.rebalanced), 32'(tuser[0]));
            check_field("index_error", 32'(e.index_error), 32'(tuser[1]));
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wr_data = '0;
    logic                  i_s_tvalid    = 1'b0;
    logic                  o_s_tready;
    logic [SDATA_W-1:0]    i_s_tdata     = '0;   // bin_index[5:0], zero pad
    logic                  o_m_tvalid;
    logic                  i_m_tready    = 1'b0;
    logic [MDATA_W-1:0]    o_m_tdata;            // max_load[31:0], min_load[63:32]
    logic [MUSER_W-1:0]    o_m_tuser;            // rebalanced[0], index_error[1]

    ring_balance_tracker tracker;
    bit                  src_steady    = 1'b0;
    bit                  sink_steady   = 1'b0;
    bit                  sink_hold_req = 1'b0;
    int                  settings_seen = 0;

    ring_load_balancer_top #(
        .MAX_BINS(MAX_BINS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result transfers are checked at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            tracker.compare_result(o_m_tdata, o_m_tuser);
    end

    // result side pacing, with one long hold-off on request
    initial begin : sink_pacing
        int roll;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req) begin
                i_m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(negedge i_clk);
                sink_hold_req = 1'b0;
            end else if (sink_steady) begin
                i_m_tready <= 1'b1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 65) begin
                    i_m_tready <= 1'b1;
                end else if (roll < 97) begin
                    i_m_tready <= 1'b0;
                end else begin
                    i_m_tready <= 1'b0;
                    repeat ($urandom_range(8, 60)) @(negedge i_clk);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet = 0;
            else quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // one configuration write, block idle
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= idx;
        i_cfg_wr_data <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tracker.set_register(idx, data);
        @(negedge i_clk);
    endtask

    // offer one bin index after a random gap and wait for its transfer
    task automatic send_bin(input logic [IDX_W-1:0] idx);
        int gap;
        int roll;
        roll = $urandom_range(0, 99);
        if (src_steady || roll < 60) gap = 0;
        else if (roll < 95) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 50);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(SDATA_W - IDX_W){1'b0}}, idx};
        do @(posedge i_clk); while (!o_s_tready);
        tracker.add_unit(idx);
        @(negedge i_clk);
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_ring(input logic [CFG_DATA_W-1:0] cnt_data,
                            input logic [ALPHA_W-1:0] alpha);
        drain();
        write_reg(CFG_BIN_COUNT, cnt_data);
        write_reg(CFG_ALPHA, alpha);
        settings_seen++;
    endtask

    initial begin : stimulus
        int                 p;
        int                 roll;
        int                 n_used;
        int                 hot;
        int                 valid_items;
        logic [IDX_W-1:0]   idx;
        logic [COUNT_W-1:0] cnt;
        logic [ALPHA_W-1:0] alpha;

        tracker = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: first bump rebalances against an empty bin, then bad indexes
        send_bin(6'd0);
        send_bin(6'd1);
        send_bin(6'd1);
        send_bin(6'd63);
        send_bin(6'd2);
        // zero bins in use, upper data bits set: every index is an error
        set_ring(16'hFF80, ALPHA_RESET);
        send_bin(6'd0);
        send_bin(6'd63);
        // single bin is its own minimum
        set_ring(16'd1, ALPHA_RESET);
        send_bin(6'd0);
        send_bin(6'd0);
        send_bin(6'd1);
        // count above the ring size, zero alpha
        set_ring(16'd127, 16'd0);
        send_bin(6'd63);
        send_bin(6'd0);
        send_bin(6'd32);
        send_bin(6'd63);
        send_bin(6'd1);
        // alpha below one, hot bin may be the minimum itself
        set_ring(16'd4, 16'd255);
        send_bin(6'd0);
        send_bin(6'd0);
        send_bin(6'd1);
        send_bin(6'd2);
        send_bin(6'd3);
        send_bin(6'd3);
        // largest alpha
        set_ring(16'd64, 16'hFFFF);
        send_bin(6'd63);
        send_bin(6'd31);

        // random phases, skewed toward one hot bin so loads become uneven
        for (p = 0; p < RAND_PHASES; p++) begin
            if (p == 0) begin
                cnt   = 7'd64;
                alpha = 16'd256;
            end else if (p == 1) begin
                cnt   = 7'd2;
                alpha = 16'hFFFF;
            end else if (p == 2) begin
                cnt   = 7'd127;
                alpha = ALPHA_RESET;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 60) cnt = 7'($urandom_range(2, 16));
                else if (roll < 85) cnt = 7'($urandom_range(17, 64));
                else cnt = 7'($urandom_range(65, 127));
                roll = $urandom_range(0, 99);
                if (roll < 50) alpha = 16'($urandom_range(256, 2000));
                else if (roll < 70) alpha = 16'($urandom_range(2000, 65535));
                else if (roll < 80) alpha = 16'd256;
                else if (roll < 90) alpha = 16'hFFFF;
                else alpha = 16'($urandom_range(0, 255));
            end
            set_ring({9'($urandom_range(0, 511)), cnt}, alpha);
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            // long receiver hold-off while the sender keeps offering
            if (p == 1) begin
                sink_steady   = 1'b0;
                sink_hold_req = 1'b1;
            end
            n_used      = (cnt > MAX_BINS) ? MAX_BINS : int'(cnt);
            hot         = $urandom_range(0, n_used - 1);
            valid_items = 0;
            while (valid_items < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) idx = IDX_W'($urandom_range(0, 63));
                else if (roll < 60) idx = IDX_W'(hot);
                else idx = IDX_W'($urandom_range(0, n_used - 1));
                if ($urandom_range(0, 29) == 0) hot = $urandom_range(0, n_used - 1);
                send_bin(idx);
                if (int'(idx) < n_used) valid_items++;
            end
        end

        // wait out the last results and any late extra transfer
        drain();
        sink_steady = 1'b1;
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("checked %0d results over %0d register settings", tracker.checked,
                 settings_seen);
        $display("with %0d rebalances and %0d index errors", tracker.rebal_seen,
                 tracker.err_seen);
        if (tracker.fails == 0 && tracker.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0t: %0d failures, %0d results missing", $time, tracker.fails,
                     tracker.pending());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: ring_load_balancer_top.f
+incdir+design
design/rlb_pkg.sv
design/rlb_ram.sv
design/ring_load_balancer_top.sv
design/rlb_checker.sv
test/tb_ring_load_balancer_top.sv
